// File: rtl/tlvp_pkg.sv
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types, codes and tag tables of the tag-length-value element header
// parser.
// ----------------------------------------------------------------------------
package tlvp_pkg;

  localparam logic [7:0] TagCount = 8'd15;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_NEG_LEN  = 2'd2,
    ST_BAD_TAG  = 2'd3
  } status_t;

  // One element report as found by the front end; the back end forms the
  // offsets and sizes from it.
  typedef struct packed {
    logic [7:0]  tag;
    logic [63:0] start;
    logic [3:0]  ps;
    logic [63:0] len;
    logic [63:0] pos;
    status_t     status;
  } evt_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_flags_t;

  function automatic logic [3:0] value_size(input logic [7:0] tag);
    logic [3:0] vs;
    case (tag) inside
      [8'd0:8'd1]: vs = 4'd1;
      [8'd2:8'd3]: vs = 4'd2;
      [8'd4:8'd5]: vs = 4'd4;
      [8'd6:8'd8]: vs = 4'd8;
      default:     vs = 4'd0;
    endcase
    return vs;
  endfunction

  function automatic logic [3:0] prefix_size(input logic [7:0] tag);
    logic [3:0] ps;
    case (tag) inside
      8'd9:          ps = 4'd1;
      8'd10:         ps = 4'd2;
      8'd11:         ps = 4'd4;
      [8'd12:8'd14]: ps = 4'd8;
      default:       ps = 4'd0;
    endcase
    return ps;
  endfunction

endpackage

// File: rtl/tlvp_front.sv
// ----------------------------------------------------------------------------
// tlvp_front
// Accepts one buffer byte per cycle unless the queue is full, tracks the
// current element and posts one report per element that completes or fails.
// ----------------------------------------------------------------------------
module tlvp_front
  import tlvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       q_full,
  output logic       push,
  output evt_t       push_evt
);

  typedef enum logic [1:0] {
    PH_TAG    = 2'd0,
    PH_PREFIX = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        hold_r, hold_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [3:0]  pre_r, pre_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] pay_r, pay_nxt;
  logic [63:0] offset_r, offset_nxt;
  logic [63:0] start_r, start_nxt;

  logic        accept;
  logic [7:0]  tag_cur;
  logic [63:0] start_cur;
  logic [3:0]  vs;
  logic [3:0]  ps;
  logic [5:0]  sign_idx;
  logic [63:0] acc_shift;
  logic [3:0]  pre_dec;
  logic [63:0] pay_dec;

  assign accept    = in_valid && !q_full;
  assign tag_cur   = (phase_r == PH_TAG) ? in_data_byte : tag_r;
  assign start_cur = (phase_r == PH_TAG) ? offset_r : start_r;
  assign vs        = value_size(tag_cur);
  assign ps        = prefix_size(tag_cur);
  assign sign_idx  = 6'({ps, 3'b000} - 7'd1);
  assign acc_shift = {acc_r[55:0], in_data_byte};
  assign pre_dec   = (pre_r != 4'd0) ? pre_r - 4'd1 : 4'd0;
  assign pay_dec   = (pay_r != 64'd0) ? pay_r - 64'd1 : 64'd0;

  always_comb begin
    phase_nxt  = phase_r;
    hold_nxt   = hold_r;
    tag_nxt    = tag_r;
    pre_nxt    = pre_r;
    acc_nxt    = acc_r;
    pay_nxt    = pay_r;
    offset_nxt = offset_r;
    start_nxt  = start_r;
    push       = 1'b0;
    push_evt        = '0;
    push_evt.tag    = tag_cur;
    push_evt.start  = start_cur;
    push_evt.ps     = ps;
    push_evt.pos    = offset_r;
    push_evt.status = ST_OK;
    if (accept) begin
      if (!hold_r) begin
        tag_nxt   = tag_cur;
        start_nxt = start_cur;
        case (phase_r)
          PH_TAG: begin
            if (tag_cur >= TagCount) begin
              push            = 1'b1;
              push_evt.status = ST_BAD_TAG;
              hold_nxt        = 1'b1;
            end else if (vs != 4'd0) begin
              pay_nxt   = 64'(vs);
              phase_nxt = PH_BODY;
            end else begin
              pre_nxt   = ps;
              acc_nxt   = 64'd0;
              phase_nxt = PH_PREFIX;
            end
          end
          PH_PREFIX: begin
            acc_nxt = acc_shift;
            pre_nxt = pre_dec;
            if (pre_dec == 4'd0) begin
              if (acc_shift[sign_idx]) begin
                push            = 1'b1;
                push_evt.status = ST_NEG_LEN;
                hold_nxt        = 1'b1;
                phase_nxt       = PH_TAG;
              end else if (acc_shift == 64'd0) begin
                push      = 1'b1;
                phase_nxt = PH_TAG;
              end else begin
                pay_nxt   = acc_shift;
                phase_nxt = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            pay_nxt = pay_dec;
            if (pay_dec == 64'd0) begin
              push         = 1'b1;
              push_evt.len = (vs != 4'd0) ? 64'(vs) : acc_r;
              phase_nxt    = PH_TAG;
            end
          end
          default: begin
            phase_nxt = PH_TAG;
          end
        endcase
        if (in_last_byte && !push && phase_nxt != PH_TAG) begin
          push            = 1'b1;
          push_evt.status = ST_TRUNC;
          if (vs != 4'd0) begin
            push_evt.len = 64'(vs);
          end else if (phase_nxt == PH_BODY) begin
            push_evt.len = acc_nxt;
          end else begin
            push_evt.len = 64'd0;
          end
        end
      end
      if (in_last_byte) begin
        phase_nxt  = PH_TAG;
        hold_nxt   = 1'b0;
        pre_nxt    = 4'd0;
        pay_nxt    = 64'd0;
        offset_nxt = 64'd0;
      end else begin
        offset_nxt = offset_r + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG;
      hold_r   <= 1'b0;
      offset_r <= 64'd0;
      pre_r    <= 4'd0;
      pay_r    <= 64'd0;
    end else begin
      phase_r  <= phase_nxt;
      hold_r   <= hold_nxt;
      offset_r <= offset_nxt;
      pre_r    <= pre_nxt;
      pay_r    <= pay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= tag_nxt;
    acc_r   <= acc_nxt;
    start_r <= start_nxt;
  end

endmodule

// File: rtl/tlvp_queue.sv
// ----------------------------------------------------------------------------
// tlvp_queue
// Short first-in first-out queue of element reports between the front end
// and the back end.
// ----------------------------------------------------------------------------
module tlvp_queue
  import tlvp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  evt_t         push_evt,
  input  logic         pop,
  output evt_t         head_evt,
  output queue_flags_t flags
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  evt_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign head_evt    = mem[rd_ptr_r];
  assign flags.empty = (count_r == '0);
  assign flags.full  = (count_r == CntW'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_evt;
    end
  end

endmodule

// File: rtl/tlvp_back.sv
// ----------------------------------------------------------------------------
// tlvp_back
// Takes element reports from the queue, forms the payload offset and the
// element size, and holds each result in the output register.
// ----------------------------------------------------------------------------
module tlvp_back
  import tlvp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  evt_t         head_evt,
  input  queue_flags_t flags,
  output logic         pop,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [7:0]   out_element_tag,
  output logic [62:0]  out_payload_offset,
  output logic [62:0]  out_payload_length,
  output logic [63:0]  out_element_size,
  output logic [1:0]   out_status
);

  logic        valid_r, valid_nxt;
  logic [7:0]  tag_r;
  logic [62:0] offset_r;
  logic [62:0] length_r;
  logic [63:0] size_r;
  status_t     status_r;

  logic [63:0] offset_sum;
  logic [63:0] size_full;
  logic [63:0] size_trunc;

  assign pop        = !flags.empty && (!valid_r || !out_stall);
  assign offset_sum = head_evt.start + 64'd1 + 64'(head_evt.ps);
  assign size_full  = 64'd1 + 64'(head_evt.ps) + head_evt.len;
  assign size_trunc = head_evt.pos - head_evt.start + 64'd1;

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tag_r    <= head_evt.tag;
      offset_r <= offset_sum[62:0];
      length_r <= head_evt.len[62:0];
      size_r   <= (head_evt.status == ST_TRUNC) ? size_trunc : size_full;
      status_r <= head_evt.status;
    end
  end

  assign out_valid          = valid_r;
  assign out_element_tag    = tag_r;
  assign out_payload_offset = offset_r;
  assign out_payload_length = length_r;
  assign out_element_size   = size_r;
  assign out_status         = 2'(status_r);

endmodule

// File: rtl/tlv_element_header_parser_unit.sv
// ----------------------------------------------------------------------------
// tlv_element_header_parser_unit
// Splits a byte stream into tag-length-value elements and reports the tag,
// payload offset, payload length, total size and status of each element.
// ----------------------------------------------------------------------------
// The unit takes one buffer byte per cycle and gives at most one result per
// byte, so it sustains one beat per cycle on both sides while out_stall is low
// and the queue is not full. A front end parses each byte; its reports pass
// through a queue of QUEUE_DEPTH entries to a back end that forms the offsets
// and sizes and holds the result in an output register; a result is stored in
// the queue and then in the output register after the byte that completes its
// element. The input is stalled only when the queue is full. After an error the
// remaining bytes of the buffer are taken and dropped until the byte marked as last.
module tlv_element_header_parser_unit
  import tlvp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_element_tag,
  output logic [62:0] out_payload_offset,
  output logic [62:0] out_payload_length,
  output logic [63:0] out_element_size,
  output logic [1:0]  out_status
);

  logic         push;
  evt_t         push_evt;
  logic         pop;
  evt_t         head_evt;
  queue_flags_t flags;

  assign in_stall = flags.full;

  tlvp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (flags.full),
    .push         (push),
    .push_evt     (push_evt)
  );

  tlvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head_evt (head_evt),
    .flags    (flags)
  );

  tlvp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_evt           (head_evt),
    .flags              (flags),
    .pop                (pop),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_element_tag    (out_element_tag),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_element_size   (out_element_size),
    .out_status         (out_status)
  );

endmodule
